// ----- design/lfu_key_slot_table_core_macros.svh -----
// Assertion macros shared by the key slot table RTL.
// Both expect signals named clk and rst_n in the scope that uses them.
`ifndef LFU_KEY_SLOT_TABLE_CORE_MACROS_SVH
`define LFU_KEY_SLOT_TABLE_CORE_MACROS_SVH

// Property checked on every rising edge outside reset.
`define LKST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define LKST_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/lkst_pkg.sv -----
// Shared types and constants of the LFU key slot table.
// No dependencies; used by lkst_sweep and lfu_key_slot_table_core.
package lkst_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int FILL_W  = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 16;
  localparam int COUNT_W = 16;
  localparam int SLOT_W  = 4;
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

  typedef struct packed {
    logic               busy;
    logic               found;
    logic [IDX_W-1:0]   found_slot;
    logic [COUNT_W-1:0] found_cnt;
    logic [IDX_W-1:0]   best_slot;
    logic [KEY_W-1:0]   best_key;
  } sweep_stat_t;

endpackage

// ----- design/lfu_key_slot_table_core.sv -----
// LFU key slot table, top level. Uses lkst_pkg, lkst_sweep and the macros header.
// One key beat at a time: in_stall holds a new beat until the last result is loaded.
// The sweep through the single-read-port entry memory, one slot a cycle, sets the pace.
// Reset: fill count cleared, capacity 16, no clearing pass; slots at or above the fill
//   count are never read, so the memory contents need no reset.
`include "lfu_key_slot_table_core_macros.svh"

module lfu_key_slot_table_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [lkst_pkg::CAP_W-1:0]  cfg_wr_data,
  // key beats in
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lkst_pkg::KEY_W-1:0]  in_key,
  // result beats out
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [lkst_pkg::SLOT_W-1:0] out_slot,
  output logic                        out_evicted,
  output logic [lkst_pkg::KEY_W-1:0]  out_evicted_key,
  output logic [lkst_pkg::COUNT_W-1:0] out_use_count
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [lkst_pkg::CAP_W-1:0]   cap_r;
  logic [lkst_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic [lkst_pkg::KEY_W-1:0]   key_r;

  // output register: parts the sweep from a stalled consumer
  logic                         out_valid_r, out_valid_nxt;
  logic                         hit_r;
  logic [lkst_pkg::SLOT_W-1:0]  slot_r;
  logic                         evicted_r;
  logic [lkst_pkg::KEY_W-1:0]   evicted_key_r;
  logic [lkst_pkg::COUNT_W-1:0] use_count_r;

  lkst_pkg::sweep_stat_t stat;
  lkst_pkg::wr_req_t     wr;

  logic                         in_acc;
  logic                         retire;   // decision taken, result loaded
  logic [lkst_pkg::CMP_W-1:0]   cap_eff;
  logic                         room;
  logic [lkst_pkg::IDX_W-1:0]   dec_slot;
  logic [lkst_pkg::COUNT_W-1:0] dec_cnt;
  logic                         dec_evict;
  logic [lkst_pkg::KEY_W-1:0]   dec_old_key;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign retire   = (state_r == S_DECIDE) && (!out_valid_r || !out_stall);

  lkst_sweep u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .key   (key_r),
    .fill  (fill_r),
    .wr    (wr),
    .stat  (stat)
  );

  // capacity clamp: zero acts as one, anything above the table size as the size
  always_comb begin
    cap_eff = lkst_pkg::CMP_W'(cap_r);
    if (cap_eff == '0) begin
      cap_eff = lkst_pkg::CMP_W'(1);
    end else if (cap_eff > lkst_pkg::CMP_W'(lkst_pkg::ENTRIES)) begin
      cap_eff = lkst_pkg::CMP_W'(lkst_pkg::ENTRIES);
    end
    room = lkst_pkg::CMP_W'(fill_r) < cap_eff;
  end

  // three outcomes: hit, fill a free slot, or replace the lowest count
  always_comb begin
    dec_evict   = 1'b0;
    dec_old_key = '0;
    fill_nxt    = fill_r;
    if (stat.found) begin
      dec_slot = stat.found_slot;
      dec_cnt  = (stat.found_cnt == '1) ? stat.found_cnt
                                        : stat.found_cnt + lkst_pkg::COUNT_W'(1);
    end else if (room) begin
      dec_slot = fill_r[lkst_pkg::IDX_W-1:0];
      dec_cnt  = lkst_pkg::COUNT_W'(1);
      if (retire) begin
        fill_nxt = fill_r + lkst_pkg::FILL_W'(1);
      end
    end else begin
      dec_slot    = stat.best_slot;
      dec_cnt     = lkst_pkg::COUNT_W'(1);
      dec_evict   = 1'b1;
      dec_old_key = stat.best_key;
    end
    wr.en       = retire;
    wr.addr     = dec_slot;
    wr.data.key = key_r;
    wr.data.cnt = dec_cnt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (!stat.busy) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (retire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (retire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= lkst_pkg::CAP_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= in_key;
    end
    if (retire) begin
      hit_r         <= stat.found;
      slot_r        <= lkst_pkg::SLOT_W'(dec_slot);
      evicted_r     <= dec_evict;
      evicted_key_r <= dec_old_key;
      use_count_r   <= dec_cnt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_slot        = slot_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = evicted_key_r;
  assign out_use_count   = use_count_r;

  // checks
  `LKST_NEVER(a_fill_bound, fill_r > lkst_pkg::FILL_W'(lkst_pkg::ENTRIES), "fill count past table size")
  `LKST_ASSERT(a_fill_step, fill_r != $past(fill_r) |-> $past(retire) && fill_r == $past(fill_r) + lkst_pkg::FILL_W'(1), "fill count moved outside a fill")
  `LKST_ASSERT(a_out_load, $rose(out_valid_r) |-> $past(state_r == S_DECIDE), "result without a decision")
  `LKST_NEVER(a_hit_evict, out_valid_r && hit_r && evicted_r, "hit and eviction together")
  `LKST_NEVER(a_sweep_idle, state_r == S_IDLE && stat.busy, "sweep running while idle")

endmodule

// ----- design/lkst_sweep.sv -----
// Entry memory plus sweep unit: reads the filled slots one per cycle,
// tracks the first key match and the lowest count. Uses lkst_pkg.
module lkst_sweep (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lkst_pkg::KEY_W-1:0] key,
  input  logic [lkst_pkg::FILL_W-1:0] fill,
  input  lkst_pkg::wr_req_t          wr,
  output lkst_pkg::sweep_stat_t      stat
);

  lkst_pkg::entry_t mem [lkst_pkg::ENTRIES];
  lkst_pkg::entry_t rd_data_r;

  logic                          active_r;
  logic                          pend_r;
  logic [lkst_pkg::FILL_W-1:0]   issue_r;
  logic [lkst_pkg::IDX_W-1:0]    data_idx_r;
  logic                          found_r;
  logic [lkst_pkg::IDX_W-1:0]    found_slot_r;
  logic [lkst_pkg::COUNT_W-1:0]  found_cnt_r;
  logic [lkst_pkg::IDX_W-1:0]    best_slot_r;
  logic [lkst_pkg::KEY_W-1:0]    best_key_r;
  logic [lkst_pkg::COUNT_W-1:0]  best_cnt_r;
  logic                          rd_en;

  assign rd_en = active_r && (issue_r < fill);

  // single port each way; writes only happen between sweeps
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[issue_r[lkst_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
      issue_r  <= '0;
      found_r  <= 1'b0;
    end else if (start) begin
      active_r <= 1'b1;
      pend_r   <= 1'b0;
      issue_r  <= '0;
      found_r  <= 1'b0;
    end else if (active_r) begin
      pend_r <= rd_en;
      if (rd_en) begin
        issue_r <= issue_r + lkst_pkg::FILL_W'(1);
      end
      if (!rd_en && !pend_r) begin
        active_r <= 1'b0;
      end
      if (pend_r && !found_r && rd_data_r.key == key) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_idx_r <= issue_r[lkst_pkg::IDX_W-1:0];
    end
    if (pend_r) begin
      if (!found_r && rd_data_r.key == key) begin
        found_slot_r <= data_idx_r;
        found_cnt_r  <= rd_data_r.cnt;
      end
      // strict compare keeps the lowest slot on ties
      if (data_idx_r == '0 || rd_data_r.cnt < best_cnt_r) begin
        best_slot_r <= data_idx_r;
        best_key_r  <= rd_data_r.key;
        best_cnt_r  <= rd_data_r.cnt;
      end
    end
  end

  always_comb begin
    stat.busy       = active_r;
    stat.found      = found_r;
    stat.found_slot = found_slot_r;
    stat.found_cnt  = found_cnt_r;
    stat.best_slot  = best_slot_r;
    stat.best_key   = best_key_r;
  end

endmodule

// ----- tb/tb_lfu_key_slot_table_core.sv -----
// Self-checking testbench for lfu_key_slot_table_core: directed and random key beats,
// a behavioural LFU table predictor and in-order result checking.
// Depends on lkst_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_lfu_key_slot_table_core;

  // Watchdog: cycles with no beat on either channel before the run is abandoned.
  // The slowest beat is one full sweep plus random stalls; the long output hold is LONG_HOLD.
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  // Drain margin after the last result: one full sweep and some slack.
  localparam int TAIL_CYCLES = 25;
  localparam int POOL_N      = 24;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                         hit;
    logic [lkst_pkg::SLOT_W-1:0]  slot;
    logic                         evicted;
    logic [lkst_pkg::KEY_W-1:0]   evicted_key;
    logic [lkst_pkg::COUNT_W-1:0] use_count;
  } lookup_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [lkst_pkg::CAP_W-1:0]   cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [lkst_pkg::KEY_W-1:0]   in_key = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_hit;
  logic [lkst_pkg::SLOT_W-1:0]  out_slot;
  logic                         out_evicted;
  logic [lkst_pkg::KEY_W-1:0]   out_evicted_key;
  logic [lkst_pkg::COUNT_W-1:0] out_use_count;

  always #6 clk = ~clk;

  lfu_key_slot_table_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_use_count   (out_use_count)
  );

  // ---------------------------------------------------------------------------
  // Shadow table. Mirrors the resident keys, their use counts, the fill level
  // and the capacity register as the block should hold them.
  // ---------------------------------------------------------------------------
  logic [lkst_pkg::KEY_W-1:0]   key_tab [lkst_pkg::ENTRIES];
  logic [lkst_pkg::COUNT_W-1:0] cnt_tab [lkst_pkg::ENTRIES];
  int                           resident_n;
  logic [lkst_pkg::CAP_W-1:0]   cap_model;

  logic [lkst_pkg::KEY_W-1:0] key_backlog[$];       // keys waiting to be driven
  lookup_t                    expected_lookups[$];  // predicted results, oldest first
  lookup_t                    predicted;
  lookup_t                    want;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  int mismatches  = 0;
  int n_checked   = 0;
  int n_hits      = 0;
  int n_evictions = 0;
  int n_saturated = 0;

  // One access to the table: lookup, then fill or replace, as the block does it.
  function automatic lookup_t lfu_lookup(input logic [lkst_pkg::KEY_W-1:0] k);
    lookup_t                      r;
    int                           i;
    int                           idx;
    int                           limit;
    bit                           found;
    logic [lkst_pkg::COUNT_W-1:0] lowest;
    r     = '0;
    found = 1'b0;
    idx   = 0;
    // capacity 0 behaves as 1, anything past the table size as the table size
    limit = (cap_model == 0) ? 1 :
            ((cap_model > lkst_pkg::ENTRIES) ? lkst_pkg::ENTRIES : int'(cap_model));
    for (i = 0; i < resident_n; i++) begin
      if (!found && key_tab[i] == k) begin
        idx   = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (cnt_tab[idx] != '1) cnt_tab[idx] = cnt_tab[idx] + lkst_pkg::COUNT_W'(1);
    end else if (resident_n < limit) begin
      idx          = resident_n;
      key_tab[idx] = k;
      cnt_tab[idx] = lkst_pkg::COUNT_W'(1);
      resident_n++;
    end else begin
      // full (or capacity dropped under the fill level): lowest count goes,
      // the first such slot on a tie; all filled slots take part
      lowest = cnt_tab[0];
      idx    = 0;
      for (i = 1; i < resident_n; i++) begin
        if (cnt_tab[i] < lowest) begin
          lowest = cnt_tab[i];
          idx    = i;
        end
      end
      r.evicted     = 1'b1;
      r.evicted_key = key_tab[idx];
      key_tab[idx]  = k;
      cnt_tab[idx]  = lkst_pkg::COUNT_W'(1);
    end
    r.slot      = lkst_pkg::SLOT_W'(idx);
    r.use_count = cnt_tab[idx];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Key driver. A stalled beat is held; otherwise the next key goes out unless
  // the sender decides to sit this cycle out. The prediction is made at the
  // edge the beat is taken, so it sees the capacity in force at that moment.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = lfu_lookup(in_key);
        expected_lookups.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (key_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_key   <= key_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver. Each taken beat is matched to the oldest
  // prediction. The stall is random per cycle, or held high through a long hold-off
  // whenever the stimulus asks for one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected beat: hit %0b slot %0d evicted %0b key %h count %0d",
                     $time, out_hit, out_slot, out_evicted, out_evicted_key, out_use_count);
          mismatches++;
        end else begin
          want = expected_lookups.pop_front();
          n_checked++;
          if (out_hit !== want.hit || out_slot !== want.slot ||
              out_evicted !== want.evicted || out_evicted_key !== want.evicted_key ||
              out_use_count !== want.use_count) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch, expected hit %0b slot %0d evicted %0b key %h count %0d",
                       $time, want.hit, want.slot, want.evicted, want.evicted_key,
                       want.use_count);
              $display("%0t:           got hit %0b slot %0d evicted %0b key %h count %0d",
                       $time, out_hit, out_slot, out_evicted, out_evicted_key,
                       out_use_count);
            end
            mismatches++;
          end
          if (want.hit) n_hits++;
          if (want.evicted) n_evictions++;
          if (want.hit && want.use_count == '1) n_saturated++;
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: gives up when the quiet count with no beat on either side reaches QUIET_LIMIT.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat for %0d cycles, %0d keys queued, %0d results outstanding",
             $time, QUIET_LIMIT, key_backlog.size(), expected_lookups.size());
    $display("tb_lfu_key_slot_table_core: FAIL");
    $finish;
  end

  // Block until every queued key has gone in and every result has come out.
  task automatic wait_drained();
    while (key_backlog.size() != 0 || in_valid || expected_lookups.size() != 0)
      @(posedge clk);
  endtask

  // Capacity write; only issued once the block has drained.
  task automatic write_capacity(input logic [lkst_pkg::CAP_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cap_model    = value;
  endtask

  // Random phase: mostly keys from a small hot pool (skewed toward its head,
  // so counts spread out and replacement has real choices), the rest noise.
  task automatic run_random(input logic [lkst_pkg::CAP_W-1:0] cap, input idle_mode_t mode,
                            input int n_keys, input bit long_hold);
    logic [lkst_pkg::KEY_W-1:0] pool [POOL_N];
    int                         a;
    int                         b;
    write_capacity(cap);
    send_gap_pct   = (mode == IDLE_SEND) ? 50 : ((mode == IDLE_BOTH) ? 14 : 0);
    recv_stall_pct = (mode == IDLE_RECV) ? 50 : ((mode == IDLE_BOTH) ? 14 : 0);
    for (int i = 0; i < POOL_N; i++) pool[i] = lkst_pkg::KEY_W'($urandom);
    if (long_hold) hold_requests++;
    for (int i = 0; i < n_keys; i++) begin
      if ($urandom_range(99) < 85) begin
        a = $urandom_range(POOL_N - 1);
        b = $urandom_range(POOL_N - 1);
        key_backlog.push_back(pool[(a < b) ? a : b]);
      end else begin
        key_backlog.push_back(lkst_pkg::KEY_W'($urandom));
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < lkst_pkg::ENTRIES; i++) begin
      key_tab[i] = '0;
      cnt_tab[i] = '0;
    end
    resident_n = 0;
    cap_model  = lkst_pkg::CAP_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // capacity 0 acts as one slot; key 0 is an ordinary key
    write_capacity(lkst_pkg::CAP_W'(0));
    key_backlog.push_back(16'h0000);
    key_backlog.push_back(16'h0000);
    key_backlog.push_back(16'hFFFF);
    key_backlog.push_back(16'hFFFF);

    // one slot: the new key replaces, then one key is hit repeatedly so its
    // count climbs well above anything else in the table
    write_capacity(lkst_pkg::CAP_W'(1));
    key_backlog.push_back(16'h1234);
    for (int i = 0; i < 20; i++) key_backlog.push_back(16'hA5A5);

    // second slot; the busy entry survives, the fresh one is the victim
    write_capacity(lkst_pkg::CAP_W'(2));
    key_backlog.push_back(16'h5A5A);
    key_backlog.push_back(16'hA5A5);
    key_backlog.push_back(16'h0001);

    // capacity past the table size clamps to 16: fill the rest of the table
    write_capacity(lkst_pkg::CAP_W'(31));
    for (int i = 1; i < 15; i++) key_backlog.push_back(lkst_pkg::KEY_W'(1) << i);
    wait_drained();

    // table now full for good; capacity below the fill level leaves it full
    run_random(lkst_pkg::CAP_W'(16), IDLE_NONE, 140, 1'b0);
    run_random(lkst_pkg::CAP_W'(8),  IDLE_SEND, 140, 1'b0);
    run_random(lkst_pkg::CAP_W'(1),  IDLE_RECV, 140, 1'b1);
    run_random(lkst_pkg::CAP_W'(20), IDLE_BOTH, 140, 1'b1);
    run_random(lkst_pkg::CAP_W'(0),  IDLE_NONE, 140, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_lookups.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_lookups.size());
      mismatches++;
    end

    $display("checked %0d lookups: %0d hits, %0d replacements, %0d hits on a saturated count",
             n_checked, n_hits, n_evictions, n_saturated);
    $display("capacity 0, 1, 2, 31, then 16, 8, 1, 20 and 0 over a full table; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb_lfu_key_slot_table_core: PASS");
    end else begin
      $display("tb_lfu_key_slot_table_core: FAIL");
    end
    $finish;
  end

endmodule
